>>> rtl/wavpcm_pkg.sv
// wavpcm_pkg: shared constants, status codes and control structs for the wav parser
// no dependencies

package wavpcm_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN  = 32'd16;
    localparam int          HEADER_LEN = 12;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_INVALID = 2'd1;
    localparam t_status ST_UNSUP   = 2'd2;
    localparam t_status ST_CORRUPT = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic step;
        logic load_res;
        logic div_start;
        logic load_sum;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic emits;
        logic is_final;
        logic div_done;
    } t_stat;

endpackage

>>> rtl/wav_pcm16_container_parser_unit.sv
// wav_pcm16_container_parser_unit: streaming riff/wave pcm16 header parser, top level
// depends on wavpcm_pkg, wavpcm_ctrl, wavpcm_dp (with wavpcm_div)
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | i_valid / o_ready  | i_file_byte, i_final_byte
//  out     | o_valid / i_ready  | o_is_sample_byte .. o_payload_bytes (9 fields)
//
// one file byte per cycle; a data byte or empty-chunk marker is registered with its item
// the final byte is followed by start, 32 bit-serial division steps, done and summary load
// input waits while the output register is full and not taken, and from the final byte
// until the summary is loaded, which itself waits for a free output register
// synchronous active-low reset clears all parse state; no clearing pass

module wav_pcm16_container_parser_unit
    import wavpcm_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_file_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_sample_byte,
    output logic [7:0]  o_sample_byte,
    output logic        o_chunk_begins,
    output logic        o_is_summary,
    output logic [1:0]  o_status,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_rate_hz,
    output logic [31:0] o_frame_total,
    output logic [31:0] o_payload_bytes
);

    t_cmd  w_cmd;
    t_stat w_stat;

    wavpcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    wavpcm_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_file_byte      (i_file_byte),
        .i_final_byte     (i_final_byte),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_is_sample_byte (o_is_sample_byte),
        .o_sample_byte    (o_sample_byte),
        .o_chunk_begins   (o_chunk_begins),
        .o_is_summary     (o_is_summary),
        .o_status         (o_status),
        .o_channel_count  (o_channel_count),
        .o_rate_hz        (o_rate_hz),
        .o_frame_total    (o_frame_total),
        .o_payload_bytes  (o_payload_bytes)
    );

endmodule

>>> rtl/wavpcm_div.sv
// wavpcm_div: restoring divider, one quotient bit per cycle
// depends on wavpcm_pkg

module wavpcm_div
    import wavpcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder,
    output logic                  o_done
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dsr;

    logic [DIVISOR_W:0]    w_trial;
    logic                  w_qbit;
    logic [DIVISOR_W-1:0]  w_rem_nx;

    assign w_trial  = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_qbit   = (w_trial >= {1'b0, r_dsr});
    assign w_rem_nx = w_qbit ? DIVISOR_W'(w_trial - {1'b0, r_dsr}) : w_trial[DIVISOR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_qbit};
            r_rem <= w_rem_nx;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

>>> rtl/wavpcm_dp.sv
// wavpcm_dp: parse state, chunk walk, fmt capture, closing checks and output payload
// depends on wavpcm_pkg and wavpcm_div

module wavpcm_dp
    import wavpcm_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_file_byte,
    input  logic        i_final_byte,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_is_sample_byte,
    output logic [7:0]  o_sample_byte,
    output logic        o_chunk_begins,
    output logic        o_is_summary,
    output logic [1:0]  o_status,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_rate_hz,
    output logic [31:0] o_frame_total,
    output logic [31:0] o_payload_bytes
);

    localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH + 1 : 33;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHDR,
        PH_BODY,
        PH_PAD,
        PH_DEAD
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_pos, n_pos;
    logic [63:0]            r_shift, n_shift;
    logic [2:0]             r_hcnt, n_hcnt;
    logic [31:0]            r_remain, n_remain;
    logic                   r_pad, n_pad;
    logic [31:0]            r_riff, n_riff;
    logic [15:0]            r_fmt, n_fmt;
    logic [15:0]            r_chan, n_chan;
    logic [31:0]            r_rate, n_rate;
    logic [15:0]            r_align, n_align;
    logic [15:0]            r_bits, n_bits;
    logic                   r_dseen, n_dseen;
    logic [31:0]            r_dlen, n_dlen;
    logic [1:0]             r_eflag, n_eflag;

    logic        r_o_isb;
    logic [7:0]  r_o_sb;
    logic        r_o_beg;
    logic        r_o_sum;
    t_status     r_o_st;
    logic [15:0] r_o_ch;
    logic [31:0] r_o_rate;
    logic [31:0] r_o_frames;
    logic [31:0] r_o_bytes;

    logic [63:0] w_shift;
    logic [31:0] w_id;
    logic [31:0] w_len;
    logic [31:0] w_idx;
    logic [31:0] w_rem_dec;
    logic        w_tag;
    logic        w_emit;
    logic        w_isb;
    logic        w_beg;
    t_status     w_status;
    logic [CMP_W-1:0] w_riff_end;
    logic [CMP_W-1:0] w_total;

    logic [31:0] w_quo;
    logic [15:0] w_rem;
    logic        w_div_done;

    wavpcm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_dlen),
        .i_divisor   (r_align),
        .o_quotient  (w_quo),
        .o_remainder (w_rem),
        .o_done      (w_div_done)
    );

    assign w_shift   = {i_file_byte, r_shift[63:8]};
    assign w_id      = w_shift[31:0];
    assign w_len     = w_shift[63:32];
    assign w_idx     = r_shift[63:32] - r_remain;
    assign w_rem_dec = r_remain - 32'd1;

    // result raised by this byte
    always_comb begin
        w_emit = 1'b0;
        w_isb  = 1'b0;
        w_beg  = 1'b0;
        if (r_phase == PH_CHDR && r_hcnt == 3'd7 && w_id == TAG_DATA && w_len == 32'd0) begin
            w_emit = 1'b1;
            w_beg  = 1'b1;
        end else if (r_phase == PH_BODY && r_shift[31:0] == TAG_DATA) begin
            w_emit = 1'b1;
            w_isb  = 1'b1;
            w_beg  = (w_idx == 32'd0);
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_shift  = r_shift;
        n_hcnt   = r_hcnt;
        n_remain = r_remain;
        n_pad    = r_pad;
        n_riff   = r_riff;
        n_fmt    = r_fmt;
        n_chan   = r_chan;
        n_rate   = r_rate;
        n_align  = r_align;
        n_bits   = r_bits;
        n_dseen  = r_dseen;
        n_dlen   = r_dlen;
        n_eflag  = r_eflag;
        w_tag    = r_eflag[0];
        if (i_cmd.step) begin
            if (r_pos != '1) begin
                n_pos = r_pos + 1'b1;
            end
            unique case (r_phase)
                PH_HEADER: begin
                    n_shift = w_shift;
                    if (r_pos == COUNT_WIDTH'(7)) begin
                        if (w_shift[31:0] != TAG_RIFF) begin
                            n_eflag[0] = 1'b1;
                        end
                        n_riff = w_shift[63:32];
                    end else if (r_pos == COUNT_WIDTH'(11)) begin
                        w_tag      = r_eflag[0] | (w_shift[63:32] != TAG_WAVE);
                        n_eflag[0] = w_tag;
                        if (w_tag) begin
                            n_phase = PH_DEAD;
                        end else begin
                            n_phase = PH_CHDR;
                            n_hcnt  = 3'd0;
                            n_pad   = 1'b0;
                        end
                    end
                end
                PH_CHDR: begin
                    n_shift = w_shift;
                    n_hcnt  = r_hcnt + 3'd1;
                    if (r_hcnt == 3'd7) begin
                        if (w_id == TAG_FMT && w_len < FMT_MIN) begin
                            n_eflag[1] = 1'b1;
                            n_phase    = PH_DEAD;
                        end else begin
                            if (w_id == TAG_DATA) begin
                                n_dseen = 1'b1;
                                n_dlen  = w_len;
                            end
                            n_remain = w_len;
                            if (w_len != 32'd0) begin
                                n_pad   = w_len[0];
                                n_phase = PH_BODY;
                            end else begin
                                n_phase = PH_CHDR;
                                n_hcnt  = 3'd0;
                                n_pad   = 1'b0;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (r_shift[31:0] == TAG_FMT) begin
                        case (w_idx)
                            32'd0:  n_fmt   = {8'h00, i_file_byte};
                            32'd1:  n_fmt   = {i_file_byte, r_fmt[7:0]};
                            32'd2:  n_chan  = {8'h00, i_file_byte};
                            32'd3:  n_chan  = {i_file_byte, r_chan[7:0]};
                            32'd4:  n_rate  = {24'h00_0000, i_file_byte};
                            32'd5:  n_rate  = r_rate | {16'h0000, i_file_byte, 8'h00};
                            32'd6:  n_rate  = r_rate | {8'h00, i_file_byte, 16'h0000};
                            32'd7:  n_rate  = r_rate | {i_file_byte, 24'h00_0000};
                            32'd12: n_align = {8'h00, i_file_byte};
                            32'd13: n_align = {i_file_byte, r_align[7:0]};
                            32'd14: n_bits  = {8'h00, i_file_byte};
                            32'd15: n_bits  = {i_file_byte, r_bits[7:0]};
                            default: ;
                        endcase
                    end
                    n_remain = w_rem_dec;
                    if (w_rem_dec == 32'd0) begin
                        if (r_pad) begin
                            n_phase = PH_PAD;
                        end else begin
                            n_phase = PH_CHDR;
                            n_hcnt  = 3'd0;
                            n_pad   = 1'b0;
                        end
                    end
                end
                PH_PAD: begin
                    n_phase = PH_CHDR;
                    n_hcnt  = 3'd0;
                    n_pad   = 1'b0;
                end
                default: ;
            endcase
            // chunk body cut off by end of file
            if (i_final_byte && n_phase == PH_BODY) begin
                n_eflag[1] = 1'b1;
            end
        end
        if (i_cmd.load_sum) begin
            n_phase  = PH_HEADER;
            n_pos    = '0;
            n_shift  = '0;
            n_hcnt   = '0;
            n_remain = '0;
            n_pad    = 1'b0;
            n_riff   = '0;
            n_fmt    = '0;
            n_chan   = '0;
            n_rate   = '0;
            n_align  = '0;
            n_bits   = '0;
            n_dseen  = 1'b0;
            n_dlen   = '0;
            n_eflag  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_shift  <= '0;
            r_hcnt   <= '0;
            r_remain <= '0;
            r_pad    <= 1'b0;
            r_riff   <= '0;
            r_fmt    <= '0;
            r_chan   <= '0;
            r_rate   <= '0;
            r_align  <= '0;
            r_bits   <= '0;
            r_dseen  <= 1'b0;
            r_dlen   <= '0;
            r_eflag  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_shift  <= n_shift;
            r_hcnt   <= n_hcnt;
            r_remain <= n_remain;
            r_pad    <= n_pad;
            r_riff   <= n_riff;
            r_fmt    <= n_fmt;
            r_chan   <= n_chan;
            r_rate   <= n_rate;
            r_align  <= n_align;
            r_bits   <= n_bits;
            r_dseen  <= n_dseen;
            r_dlen   <= n_dlen;
            r_eflag  <= n_eflag;
        end
    end

    // closing checks in priority order
    assign w_riff_end = CMP_W'(r_riff) + CMP_W'(8);
    assign w_total    = CMP_W'(r_pos);

    always_comb begin
        if (r_pos < COUNT_WIDTH'(HEADER_LEN)) begin
            w_status = ST_INVALID;
        end else if (r_eflag[0]) begin
            w_status = ST_UNSUP;
        end else if (w_riff_end > w_total) begin
            w_status = ST_CORRUPT;
        end else if (r_eflag[1]) begin
            w_status = ST_CORRUPT;
        end else if (r_fmt == 16'd0 || r_chan == 16'd0 || r_rate == 32'd0 ||
                     r_align == 16'd0 || r_bits == 16'd0 || !r_dseen) begin
            w_status = ST_CORRUPT;
        end else if (r_fmt != 16'd1) begin
            w_status = ST_UNSUP;
        end else if (r_bits != 16'd16) begin
            w_status = ST_UNSUP;
        end else if (r_align != {r_chan[14:0], 1'b0}) begin
            w_status = ST_CORRUPT;
        end else if (w_rem != 16'd0) begin
            w_status = ST_CORRUPT;
        end else begin
            w_status = ST_OK;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_o_isb    <= w_isb;
            r_o_sb     <= w_isb ? i_file_byte : 8'h00;
            r_o_beg    <= w_beg;
            r_o_sum    <= 1'b0;
            r_o_st     <= ST_OK;
            r_o_ch     <= '0;
            r_o_rate   <= '0;
            r_o_frames <= '0;
            r_o_bytes  <= '0;
        end else if (i_cmd.load_sum) begin
            r_o_isb <= 1'b0;
            r_o_sb  <= 8'h00;
            r_o_beg <= 1'b0;
            r_o_sum <= 1'b1;
            r_o_st  <= w_status;
            if (w_status == ST_OK) begin
                r_o_ch     <= r_chan;
                r_o_rate   <= r_rate;
                r_o_frames <= w_quo;
                r_o_bytes  <= r_dlen;
            end else begin
                r_o_ch     <= '0;
                r_o_rate   <= '0;
                r_o_frames <= '0;
                r_o_bytes  <= '0;
            end
        end
    end

    assign o_stat.emits    = w_emit;
    assign o_stat.is_final = i_final_byte;
    assign o_stat.div_done = w_div_done;

    assign o_is_sample_byte = r_o_isb;
    assign o_sample_byte    = r_o_sb;
    assign o_chunk_begins   = r_o_beg;
    assign o_is_summary     = r_o_sum;
    assign o_status         = r_o_st;
    assign o_channel_count  = r_o_ch;
    assign o_rate_hz        = r_o_rate;
    assign o_frame_total    = r_o_frames;
    assign o_payload_bytes  = r_o_bytes;

endmodule

>>> rtl/wavpcm_ctrl.sv
// wavpcm_ctrl: handshake and sequencing controller for the wav parser
// depends on wavpcm_pkg

module wavpcm_ctrl
    import wavpcm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SUM
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_out_free;
    logic   w_in_acc;

    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd    = '0;
        o_ready  = 1'b0;
        w_in_acc = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready  = w_out_free;
                w_in_acc = i_valid && w_out_free;
                if (w_in_acc) begin
                    o_cmd.step     = 1'b1;
                    o_cmd.load_res = i_stat.emits;
                    if (i_stat.emits) begin
                        n_ovalid = 1'b1;
                    end
                    if (i_stat.is_final) begin
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (w_out_free) begin
                    o_cmd.load_sum = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;

endmodule

>>> rtl/wavpcm_chk.sv
// wavpcm_chk: port-level assertions for the wav parser, bound to the top level
// depends on wavpcm_pkg and wav_pcm16_container_parser_unit

module wavpcm_chk
    import wavpcm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_final_byte,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_is_sample_byte,
    input logic [7:0]  o_sample_byte,
    input logic        o_chunk_begins,
    input logic        o_is_summary,
    input logic [1:0]  o_status,
    input logic [15:0] o_channel_count,
    input logic [31:0] o_rate_hz,
    input logic [31:0] o_frame_total,
    input logic [31:0] o_payload_bytes
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_byte) && $stable(o_status)
        && $stable(o_is_summary))
        else $error("output item changed while stalled");

    // failed summary carries no stream parameters
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_summary && o_status != ST_OK |->
        o_channel_count == 16'd0 && o_rate_hz == 32'd0 &&
        o_frame_total == 32'd0 && o_payload_bytes == 32'd0)
        else $error("failed summary carries parameters");

    // sample items are never summaries
    a_sample_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_sample_byte |-> !o_is_summary && o_status == ST_OK)
        else $error("sample item marked as summary");

    // non-sample, non-summary item is an empty data chunk marker
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_sample_byte && !o_is_summary |-> o_chunk_begins &&
        o_sample_byte == 8'h00)
        else $error("stray result item");

    // final byte closes input while the summary is worked out
    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_final_byte |=> !o_ready)
        else $error("input taken during summary");

endmodule

bind wav_pcm16_container_parser_unit wavpcm_chk u_chk (.*);

>>> dv/wav_pcm16_container_parser_unit_tb.sv
// wav_pcm16_container_parser_unit_tb: streams random and hand-built riff/wave files through
// the parser, predicting every data byte, empty-chunk mark and closing summary in the bench
// depends on wavpcm_pkg and wav_pcm16_container_parser_unit

module wav_pcm16_container_parser_unit_tb;
    import wavpcm_pkg::*;

    localparam int          IDLE_LIMIT  = 2000;
    localparam int          ITEM_TARGET = 1100;
    localparam int          N_DIRECTED  = 25;
    localparam logic [31:0] TAG_LIST    = 32'h5453_494c;
    localparam logic [15:0] FMT_PCM     = 16'd1;
    localparam logic [15:0] PCM_BITS    = 16'd16;

    typedef enum logic [2:0] {
        WALK_HEADER,
        WALK_CHDR,
        WALK_BODY,
        WALK_PAD,
        WALK_DEAD
    } t_walk_phase;

    typedef enum int {
        CK_FMT,
        CK_DATA,
        CK_OTHER
    } t_chunk_kind;

    typedef struct packed {
        logic        is_sample_byte;
        logic [7:0]  sample_byte;
        logic        chunk_begins;
        logic        is_summary;
        t_status     status;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [31:0] frame_total;
        logic [31:0] payload_bytes;
    } t_wav_result;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       final_byte;
        logic       typed;
        logic       has_summary;
        t_status    status;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_file_byte;
    logic        i_final_byte;
    logic        o_valid;
    logic        i_ready;
    logic        o_is_sample_byte;
    logic [7:0]  o_sample_byte;
    logic        o_chunk_begins;
    logic        o_is_summary;
    logic [1:0]  o_status;
    logic [15:0] o_channel_count;
    logic [31:0] o_rate_hz;
    logic [31:0] o_frame_total;
    logic [31:0] o_payload_bytes;

    // short file, header-only file, bad riff tag
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{8'hff, 1'b1, 1'b1, 1'b1, ST_INVALID},
        '{8'h52, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h49, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h46, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h46, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h04, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h57, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h41, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h56, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h45, 1'b1, 1'b0, 1'b0, ST_OK},
        '{8'h52, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h49, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h46, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h58, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'hff, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'hff, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'hff, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'hff, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h57, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h41, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h56, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h45, 1'b1, 1'b1, 1'b1, ST_UNSUP}
    };

    // predictor state
    logic [31:0] seen_count;
    t_walk_phase walk_phase;
    logic [63:0] hdr_window;
    logic [31:0] body_left;
    logic        pad_due;
    logic [31:0] riff_len;
    logic [15:0] fmt_code;
    logic [15:0] fmt_channels;
    logic [31:0] fmt_rate;
    logic [15:0] fmt_align;
    logic [15:0] fmt_bits;
    logic        got_data;
    logic [31:0] data_len;
    logic        tag_bad;
    logic        walk_bad;
    int          chdr_count;

    t_wav_result byte_results [$];
    t_wav_result awaited_results [$];
    logic [7:0]  file_bytes [$];
    int          mismatches = 0;
    int          fed_items = 0;
    int          idle_cycles = 0;
    logic        quiet = 1'b0;

    wav_pcm16_container_parser_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_file_byte      (i_file_byte),
        .i_final_byte     (i_final_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_is_sample_byte (o_is_sample_byte),
        .o_sample_byte    (o_sample_byte),
        .o_chunk_begins   (o_chunk_begins),
        .o_is_summary     (o_is_summary),
        .o_status         (o_status),
        .o_channel_count  (o_channel_count),
        .o_rate_hz        (o_rate_hz),
        .o_frame_total    (o_frame_total),
        .o_payload_bytes  (o_payload_bytes)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] merge16(logic [15:0] f, logic hi, logic [7:0] b);
        return hi ? {b, f[7:0]} : {8'h00, b};
    endfunction

    task automatic clear_walker();
        seen_count   = '0;
        walk_phase   = WALK_HEADER;
        hdr_window   = '0;
        body_left    = '0;
        pad_due      = 1'b0;
        riff_len     = '0;
        fmt_code     = '0;
        fmt_channels = '0;
        fmt_rate     = '0;
        fmt_align    = '0;
        fmt_bits     = '0;
        got_data     = 1'b0;
        data_len     = '0;
        tag_bad      = 1'b0;
        walk_bad     = 1'b0;
        chdr_count   = 0;
    endtask

    task automatic open_chunk_header();
        walk_phase = WALK_CHDR;
        chdr_count = 0;
        pad_due    = 1'b0;
    endtask

    task automatic parse_wav_byte(input logic [7:0] b, input logic last);
        logic [31:0] pos;
        logic [31:0] id;
        logic [31:0] len;
        logic [31:0] idx;
        t_status     st;
        t_wav_result r;
        byte_results.delete();
        pos = seen_count;
        if (seen_count != '1) begin
            seen_count++;
        end
        case (walk_phase)
            WALK_HEADER: begin
                hdr_window = {b, hdr_window[63:8]};
                if (pos == 32'd7) begin
                    if (hdr_window[31:0] != TAG_RIFF) begin
                        tag_bad = 1'b1;
                    end
                    riff_len = hdr_window[63:32];
                end else if (pos == 32'd11) begin
                    if (hdr_window[63:32] != TAG_WAVE) begin
                        tag_bad = 1'b1;
                    end
                    if (tag_bad) begin
                        walk_phase = WALK_DEAD;
                    end else begin
                        open_chunk_header();
                    end
                end
            end
            WALK_CHDR: begin
                hdr_window = {b, hdr_window[63:8]};
                chdr_count++;
                if (chdr_count >= 8) begin
                    id  = hdr_window[31:0];
                    len = hdr_window[63:32];
                    if (id == TAG_FMT && len < FMT_MIN) begin
                        walk_bad   = 1'b1;
                        walk_phase = WALK_DEAD;
                    end else begin
                        if (id == TAG_DATA) begin
                            got_data = 1'b1;
                            data_len = len;
                            if (len == 0) begin
                                r = '0;
                                r.chunk_begins = 1'b1;
                                byte_results.push_back(r);
                            end
                        end
                        body_left = len;
                        if (len != 0) begin
                            pad_due    = len[0];
                            walk_phase = WALK_BODY;
                        end else begin
                            open_chunk_header();
                        end
                    end
                end
            end
            WALK_BODY: begin
                id  = hdr_window[31:0];
                idx = hdr_window[63:32] - body_left;
                if (id == TAG_FMT) begin
                    if (idx < 2) begin
                        fmt_code = merge16(fmt_code, idx[0], b);
                    end else if (idx < 4) begin
                        fmt_channels = merge16(fmt_channels, idx[0], b);
                    end else if (idx < 8) begin
                        if (idx == 4) begin
                            fmt_rate = {24'h0, b};
                        end else begin
                            fmt_rate = fmt_rate | (32'(b) << (8 * (idx - 4)));
                        end
                    end else if (idx == 12 || idx == 13) begin
                        fmt_align = merge16(fmt_align, idx[0], b);
                    end else if (idx == 14 || idx == 15) begin
                        fmt_bits = merge16(fmt_bits, idx[0], b);
                    end
                end else if (id == TAG_DATA) begin
                    r = '0;
                    r.is_sample_byte = 1'b1;
                    r.sample_byte    = b;
                    r.chunk_begins   = (idx == 0);
                    byte_results.push_back(r);
                end
                body_left--;
                if (body_left == 0) begin
                    if (pad_due) begin
                        walk_phase = WALK_PAD;
                    end else begin
                        open_chunk_header();
                    end
                end
            end
            WALK_PAD: begin
                open_chunk_header();
            end
            default: begin
            end
        endcase

        if (last) begin
            if (walk_phase == WALK_BODY && body_left != 0) begin
                walk_bad = 1'b1;
            end
            if (seen_count < HEADER_LEN) begin
                st = ST_INVALID;
            end else if (tag_bad) begin
                st = ST_UNSUP;
            end else if ({1'b0, riff_len} + 33'd8 > {1'b0, seen_count}) begin
                st = ST_CORRUPT;
            end else if (walk_bad) begin
                st = ST_CORRUPT;
            end else if (fmt_code == 0 || fmt_channels == 0 || fmt_rate == 0 ||
                         fmt_align == 0 || fmt_bits == 0 || !got_data) begin
                st = ST_CORRUPT;
            end else if (fmt_code != FMT_PCM) begin
                st = ST_UNSUP;
            end else if (fmt_bits != PCM_BITS) begin
                st = ST_UNSUP;
            end else if (fmt_align != 16'(fmt_channels * 2)) begin
                st = ST_CORRUPT;
            end else if (data_len % fmt_align != 0) begin
                st = ST_CORRUPT;
            end else begin
                st = ST_OK;
            end
            r = '0;
            r.is_summary = 1'b1;
            r.status     = st;
            if (st == ST_OK) begin
                r.channel_count = fmt_channels;
                r.rate_hz       = fmt_rate;
                r.frame_total   = data_len / fmt_align;
                r.payload_bytes = data_len;
            end
            byte_results.push_back(r);
            clear_walker();
        end
    endtask

    task automatic put_word(input logic [31:0] w, input int nbytes);
        for (int j = 0; j < nbytes; j++) begin
            file_bytes.push_back(w[8*j +: 8]);
        end
    endtask

    task automatic put_random(input int nbytes);
        repeat (nbytes) begin
            file_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic build_file();
        int           roll;
        int           n_chunks;
        int           n_body;
        t_chunk_kind  kind;
        logic [31:0]  len;
        logic [31:0]  tag;
        logic [31:0]  riff_val;
        logic [15:0]  ch;
        logic [15:0]  align;
        logic [127:0] fmt_img;
        logic         cut_short;
        file_bytes.delete();
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            put_random($urandom_range(1, 20));
            return;
        end
        tag = TAG_RIFF;
        if (roll < 11) begin
            tag ^= 32'h1 << $urandom_range(0, 31);
        end
        put_word(tag, 4);
        put_word(32'h0, 4);
        tag = TAG_WAVE;
        if (roll >= 11 && roll < 15) begin
            tag ^= 32'h1 << $urandom_range(0, 31);
        end
        put_word(tag, 4);

        ch        = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 4)) : 16'($urandom);
        align     = ($urandom_range(0, 9) < 8) ? 16'(ch * 2) : 16'($urandom_range(0, 9));
        n_chunks  = $urandom_range(1, 4);
        cut_short = 1'b0;
        for (int c = 0; c < n_chunks && !cut_short; c++) begin
            roll = $urandom_range(0, 9);
            if (c == 0) begin
                kind = (roll < 9) ? CK_FMT : CK_OTHER;
            end else if (c == 1) begin
                kind = (roll < 9) ? CK_DATA : CK_OTHER;
            end else begin
                kind = (roll < 2) ? CK_FMT : (roll < 5) ? CK_DATA : CK_OTHER;
            end
            case (kind)
                CK_FMT: begin
                    roll = $urandom_range(0, 19);
                    len  = (roll == 0) ? $urandom_range(0, 15) :
                           (roll < 4)  ? $urandom_range(17, 21) : 16;
                    fmt_img = {($urandom_range(0, 9) < 9) ? PCM_BITS : 16'($urandom),
                               align,
                               32'($urandom),
                               ($urandom_range(0, 19) == 0) ? 32'h0 : 32'($urandom),
                               ch,
                               ($urandom_range(0, 9) < 9) ? FMT_PCM : 16'($urandom)};
                    put_word(TAG_FMT, 4);
                    put_word(len, 4);
                    for (int j = 0; j < int'(len); j++) begin
                        file_bytes.push_back(j < 16 ? fmt_img[8*j +: 8] : 8'($urandom));
                    end
                    if (len[0] && $urandom_range(0, 9) != 0) begin
                        put_random(1);
                    end
                end
                CK_DATA: begin
                    roll = $urandom_range(0, 19);
                    if (roll < 2) begin
                        len = 0;
                    end else if (roll < 4) begin
                        len = $urandom_range(1, 40);
                    end else if (roll == 4) begin
                        len = $urandom_range(100, 1 << 20);
                    end else if (align != 0 && align <= 8) begin
                        len = align * $urandom_range(1, 8);
                    end else begin
                        len = $urandom_range(0, 16);
                    end
                    put_word(TAG_DATA, 4);
                    put_word(len, 4);
                    if (len >= 100) begin
                        // body runs past the end of the file
                        put_random($urandom_range(0, 10));
                        cut_short = 1'b1;
                    end else begin
                        put_random(int'(len));
                        if (len[0] && $urandom_range(0, 9) != 0) begin
                            put_random(1);
                        end
                    end
                end
                default: begin
                    len = $urandom_range(0, 13);
                    put_word(($urandom_range(0, 1) == 0) ? TAG_LIST : 32'($urandom), 4);
                    put_word(len, 4);
                    put_random(int'(len));
                    if (len[0] && $urandom_range(0, 9) != 0) begin
                        put_random(1);
                    end
                end
            endcase
        end
        if (!cut_short && $urandom_range(0, 9) == 0) begin
            put_random($urandom_range(1, 7));
        end

        n_body = file_bytes.size();
        roll   = $urandom_range(0, 19);
        if (roll < 15) begin
            riff_val = n_body - 8;
        end else if (roll < 17) begin
            riff_val = n_body - 7;
        end else if (roll == 17) begin
            riff_val = $urandom;
        end else if (roll == 18) begin
            riff_val = 32'h0;
        end else begin
            riff_val = 32'hffff_fff8 + $urandom_range(0, 7);
        end
        for (int j = 0; j < 4; j++) begin
            file_bytes[4 + j] = riff_val[8*j +: 8];
        end
        if ($urandom_range(0, 99) < 12) begin
            n_body = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > n_body) begin
                void'(file_bytes.pop_back());
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input logic has_summary, input t_status st);
        int          gap;
        t_wav_result r;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_file_byte  <= b;
        i_final_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        fed_items++;
        parse_wav_byte(b, last);
        if (typed) begin
            if (has_summary) begin
                r = '0;
                r.is_summary = 1'b1;
                r.status     = st;
                awaited_results.push_back(r);
            end
        end else begin
            foreach (byte_results[k]) begin
                awaited_results.push_back(byte_results[k]);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 100) begin
                $error("%s: expected %0h, got %0h", name, want, got);
            end
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_wav_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                if (mismatches < 100) begin
                    $error("output item with nothing expected");
                end
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("is_sample_byte", 32'(want.is_sample_byte), 32'(o_is_sample_byte));
                check_field("sample_byte", 32'(want.sample_byte), 32'(o_sample_byte));
                check_field("chunk_begins", 32'(want.chunk_begins), 32'(o_chunk_begins));
                check_field("is_summary", 32'(want.is_summary), 32'(o_is_summary));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("channel_count", 32'(want.channel_count), 32'(o_channel_count));
                check_field("rate_hz", want.rate_hz, o_rate_hz);
                check_field("frame_total", want.frame_total, o_frame_total);
                check_field("payload_bytes", want.payload_bytes, o_payload_bytes);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // output back-pressure
    initial begin
        int gap;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            repeat (quiet ? 1 : $urandom_range(1, 12)) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_file_byte  = 8'h00;
        i_final_byte = 1'b0;
        i_ready      = 1'b0;
        clear_walker();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_byte(directed_rows[k].file_byte, directed_rows[k].final_byte,
                      directed_rows[k].typed, directed_rows[k].has_summary,
                      directed_rows[k].status);
        end

        fed_items = 0;
        while (fed_items < ITEM_TARGET) begin
            build_file();
            quiet = ($urandom_range(0, 4) == 0);
            foreach (file_bytes[k]) begin
                send_byte(file_bytes[k], k == file_bytes.size() - 1, 1'b0, 1'b0, ST_OK);
            end
        end
        i_valid <= 1'b0;
        quiet = 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
